[hdl/rptw_pkg.sv]
// Shared codes and default sizes for the radix page table walker.
// No dependencies; imported by radix_page_table_walker.
package rptw_pkg;

	// action codes carried on s_tuser
	typedef enum logic [1:0] {
		ACT_MAP   = 2'd0,
		ACT_UNMAP = 2'd1,
		ACT_WALK  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	// default geometry of the table pool and of the page number split
	localparam int TABLE_POOL_DEF       = 256;
	localparam int LEVELS_DEF           = 4;
	localparam int TOP_INDEX_BITS_DEF   = 3;
	localparam int LOWER_INDEX_BITS_DEF = 5;
	localparam int FRAME_BITS_DEF       = 20;
	localparam int TIME_BITS_DEF        = 32;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage

[hdl/radix_page_table_walker.sv]
// Four-level sparse radix page table walker with table pool and counters.
// Depends on rptw_pkg (action codes, default sizes).
//
// channel  dir  signals                    contents
// s_*      in   tvalid tready tuser tdata  one action: kind in tuser, page/frame/time/dirty
// m_*      out  tvalid tready tdata        leaf entry after the action, cost, counters
//
// An action is accepted in ST_IDLE, then takes ST_LRD and ST_LEV per table lookup, ST_ALLOC
// per table allocated, ST_FRD and ST_FEV for the leaf entry and ST_OUT to hand out the item;
// the single port of the table store sets this order. Out of range or pool full go to ST_OUT.
// Clear runs one store entry per cycle over all TABLE_POOL*2^max(index bits) entries.
// After reset the same clearing pass runs (no item emitted) before s_tready rises.
// The block holds one item at a time; m_tdata holds until m_tready.
module radix_page_table_walker
	import rptw_pkg::*;
#(
	parameter int TABLE_POOL       = TABLE_POOL_DEF,
	parameter int LEVELS           = LEVELS_DEF,
	parameter int TOP_INDEX_BITS   = TOP_INDEX_BITS_DEF,
	parameter int LOWER_INDEX_BITS = LOWER_INDEX_BITS_DEF,
	parameter int FRAME_BITS       = FRAME_BITS_DEF,
	parameter int TIME_BITS        = TIME_BITS_DEF,
	localparam int IN_W  = ((33 + FRAME_BITS + TIME_BITS) + 7) / 8 * 8,
	localparam int OUT_W = ((8 + FRAME_BITS + 1 + 2 * TIME_BITS + 73) + 7) / 8 * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       s_tuser,  // action
	// vpn, frame, stamp, dirty, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// out_of_range, pool_full, cost, entry_valid, entry_dirty, entry_referenced,
	// entry_frame, entry_last_access, entry_load_time, walks_total, cost_total,
	// tables_in_use, zero fill
	output logic [OUT_W-1:0] m_tdata
);

	localparam int SB      = (TOP_INDEX_BITS > LOWER_INDEX_BITS) ? TOP_INDEX_BITS
		: LOWER_INDEX_BITS;
	localparam int PW      = $clog2(TABLE_POOL);
	localparam int CW      = $clog2(TABLE_POOL + 1);
	localparam int AW      = PW + SB;
	localparam int DEPTH   = TABLE_POOL * (1 << SB);
	localparam int LW      = $clog2(LEVELS);
	localparam int VPN_BITS = TOP_INDEX_BITS + (LEVELS - 1) * LOWER_INDEX_BITS;
	localparam int FW      = FRAME_BITS + 1;
	localparam int LEAF_W  = 3 + FW + 2 * TIME_BITS;
	localparam logic [31:0] TOP_MASK = 32'((64'd1 << TOP_INDEX_BITS) - 64'd1);
	localparam logic [31:0] LOW_MASK = 32'((64'd1 << LOWER_INDEX_BITS) - 64'd1);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_WIPE  = 8'b0000_0010,
		ST_LRD   = 8'b0000_0100,
		ST_LEV   = 8'b0000_1000,
		ST_ALLOC = 8'b0001_0000,
		ST_FRD   = 8'b0010_0000,
		ST_FEV   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// item fields
	logic [31:0]           vpn_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [TIME_BITS-1:0]  time_q;
	logic                  dirty_q;
	action_t               act_q;

	logic [PW-1:0] cur_q;
	logic [LW-1:0] lvl_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   walks_q;
	logic [31:0]   csum_q;
	logic [AW-1:0] wipe_q;
	logic          wipe_emit_q;

	// result fields
	logic                 oor_q, full_q, ev_q, ed_q, er_q;
	logic [2:0]           cost_q;
	logic [FW-1:0]        efr_q;
	logic [TIME_BITS-1:0] elast_q, eload_q;

	// table store
	logic [PW-1:0]     link_mem [DEPTH];
	logic [LEAF_W-1:0] leaf_mem [DEPTH];
	logic [PW-1:0]     link_rd_q;
	logic [LEAF_W-1:0] leaf_rd_q;

	logic [SB-1:0]     idx;
	logic [AW-1:0]     addr;
	logic              link_we, leaf_we;
	logic [PW-1:0]     link_wd;
	logic [LEAF_W-1:0] leaf_wd;
	logic [LEAF_W-1:0] leaf_new;
	logic [LW:0]       missing;
	logic [CW:0]       need;
	logic [32:0]       csum_inc;
	logic [31:0]       in_vpn;

	function automatic logic [SB-1:0] lvl_idx(input logic [31:0] v, input logic [LW-1:0] l);
		logic [31:0] sh;
		sh = v >> ((LEVELS - 1 - int'(l)) * LOWER_INDEX_BITS);
		return (l == '0) ? SB'(sh & TOP_MASK) : SB'(sh & LOW_MASK);
	endfunction

	assign in_vpn   = s_tdata[31:0];
	assign idx      = lvl_idx(vpn_q, lvl_q);
	assign addr     = (state_q == ST_WIPE) ? wipe_q : {cur_q, idx};
	assign missing  = (LW + 1)'(LEVELS - 1) - {1'b0, lvl_q};
	assign need     = {1'b0, cnt_q} + (CW + 1)'(missing);
	assign csum_inc = {1'b0, csum_q} + 33'(LEVELS);

	// new leaf contents for map and unmap
	always_comb begin
		leaf_new = leaf_rd_q;
		if (act_q == ACT_MAP) begin
			leaf_new = {1'b1, dirty_q, 1'b1, {1'b0, frame_q}, time_q, time_q};
		end else if (act_q == ACT_UNMAP) begin
			leaf_new = {3'b000, {FW{1'b1}}, leaf_rd_q[2*TIME_BITS-1:0]};
		end
	end

	// store write port select
	always_comb begin
		link_we = 1'b0;
		link_wd = '0;
		leaf_we = 1'b0;
		leaf_wd = leaf_new;
		case (state_q)
			ST_WIPE: begin
				link_we = 1'b1;
				leaf_we = 1'b1;
				leaf_wd = {3'b000, {FW{1'b1}}, {(2 * TIME_BITS){1'b0}}};
			end
			ST_ALLOC: begin
				link_we = 1'b1;
				link_wd = PW'(cnt_q);
			end
			ST_FEV: begin
				leaf_we = (act_q != ACT_WALK);
			end
			default: ;
		endcase
	end

	// table store, registered reads
	always_ff @(posedge clk) begin
		if (link_we) link_mem[addr] <= link_wd;
		if (leaf_we) leaf_mem[addr] <= leaf_wd;
		link_rd_q <= link_mem[addr];
		leaf_rd_q <= leaf_mem[addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			wipe_q      <= '0;
			wipe_emit_q <= 1'b0;
			cnt_q       <= CW'(1);
			walks_q     <= '0;
			csum_q      <= '0;
			cur_q       <= '0;
			lvl_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cur_q <= '0;
						lvl_q <= '0;
						if (action_t'(s_tuser) == ACT_CLEAR) begin
							wipe_q      <= '0;
							wipe_emit_q <= 1'b1;
							state_q     <= ST_WIPE;
						end else begin
							if (walks_q != SAT32) walks_q <= walks_q + 32'd1;
							state_q <= ((in_vpn >> VPN_BITS) != 32'd0) ? ST_OUT : ST_LRD;
						end
					end
				end
				ST_WIPE: begin
					wipe_q <= wipe_q + AW'(1);
					if (wipe_q == AW'(DEPTH - 1)) begin
						cnt_q   <= CW'(1);
						walks_q <= '0;
						csum_q  <= '0;
						state_q <= wipe_emit_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_LRD: state_q <= ST_LEV;
				ST_LEV: begin
					if (link_rd_q != '0) begin
						cur_q   <= link_rd_q;
						lvl_q   <= lvl_q + LW'(1);
						state_q <= (lvl_q == LW'(LEVELS - 2)) ? ST_FRD : ST_LRD;
					end else if (need > (CW + 1)'(TABLE_POOL)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_ALLOC;
					end
				end
				ST_ALLOC: begin
					cur_q   <= PW'(cnt_q);
					cnt_q   <= cnt_q + CW'(1);
					lvl_q   <= lvl_q + LW'(1);
					state_q <= (lvl_q == LW'(LEVELS - 2)) ? ST_FRD : ST_ALLOC;
				end
				ST_FRD: state_q <= ST_FEV;
				ST_FEV: begin
					csum_q  <= csum_inc[32] ? SAT32 : csum_inc[31:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture and result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			act_q   <= action_t'(s_tuser);
			vpn_q   <= in_vpn;
			frame_q <= s_tdata[32 +: FRAME_BITS];
			time_q  <= s_tdata[32 + FRAME_BITS +: TIME_BITS];
			dirty_q <= s_tdata[32 + FRAME_BITS + TIME_BITS];
			oor_q   <= (action_t'(s_tuser) != ACT_CLEAR) && ((in_vpn >> VPN_BITS) != 32'd0);
			full_q  <= 1'b0;
			cost_q  <= '0;
			ev_q    <= 1'b0;
			ed_q    <= 1'b0;
			er_q    <= 1'b0;
			efr_q   <= '1;
			elast_q <= '0;
			eload_q <= '0;
		end else if (state_q == ST_LEV && link_rd_q == '0 && need > (CW + 1)'(TABLE_POOL)) begin
			full_q <= 1'b1;
		end else if (state_q == ST_FEV) begin
			cost_q  <= 3'(LEVELS);
			{ev_q, ed_q, er_q, efr_q, elast_q, eload_q} <= leaf_new;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = OUT_W'({9'(cnt_q), csum_q, walks_q, eload_q, elast_q, efr_q,
		er_q, ed_q, ev_q, cost_q, full_q, oor_q});

	// never hand out more tables than the pool holds
	a_pool: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_POOL) && cnt_q != '0)
		else $error("table count out of range");
	// one side at a time
	a_sides: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open together");
	// a clear leaves only the root table
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && act_q == ACT_CLEAR) |-> (cnt_q == CW'(1) && walks_q == '0))
		else $error("clear left state behind");
	// a flagged result carries no cost
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (oor_q || full_q)) |-> (cost_q == '0 && !ev_q))
		else $error("flagged item with cost");

endmodule
